// ===== src/sm213_pkg.sv =====
`timescale 1ns / 1ps
package sm213_pkg;
    localparam int MemBytes = 65536;
    localparam int AddrW = $clog2(MemBytes);
    localparam int NumRegs = 8;
    localparam int RegW = $clog2(NumRegs);

    localparam logic [3:0] OP_LDI  = 4'h0;
    localparam logic [3:0] OP_LDO  = 4'h1;
    localparam logic [3:0] OP_LDX  = 4'h2;
    localparam logic [3:0] OP_STO  = 4'h3;
    localparam logic [3:0] OP_STX  = 4'h4;
    localparam logic [3:0] OP_ALU  = 4'h6;
    localparam logic [3:0] OP_SHF  = 4'h7;
    localparam logic [3:0] OP_BR   = 4'h8;
    localparam logic [3:0] OP_BEQ  = 4'h9;
    localparam logic [3:0] OP_BGT  = 4'ha;
    localparam logic [3:0] OP_JMP  = 4'hb;
    localparam logic [3:0] OP_JR   = 4'hc;
    localparam logic [3:0] OP_JIO  = 4'hd;
    localparam logic [3:0] OP_JIX  = 4'he;
    localparam logic [3:0] OP_HLT  = 4'hf;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,     // write input byte
        CMD_FETCH,    // read byte at pc + offset
        CMD_DECODE,   // latch extension word, compute data address
        CMD_DREAD,    // read data byte at address + offset
        CMD_EXEC,     // compute results, write register, update pc
        CMD_STORE,    // write stored byte at offset
        CMD_CLEAR     // zero one memory byte of the clearing pass
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] idx;    // byte offset
        logic       lat;    // capture read byte at idx-1 of previous read
        logic       pcload; // pc from config write data
    } t_ctl;

    typedef struct packed {
        logic [3:0] op;
        logic       halted;
        logic       needs_ext;
        logic       needs_data;
        logic       stores;
        logic       clear_done;
    } t_sts;
endpackage

// ===== src/sm213_instruction_step_unit.sv =====
`timescale 1ns / 1ps
// Single-issue step unit for a small eight-register teaching processor.
// Input stream (s_axis): tuser = kind (0 writes one memory byte, 1 executes
// one instruction), tdata = {load_byte, load_address}. One result per item on
// m_axis: tdata = {store_value, store_address, reg_value, reg_index, pc_after},
// tuser = {mem_written, reg_written, illegal, halted}.
// A byte load or a step while halted goes straight to the result; other steps
// run fetch (two bytes, or six for the six-byte forms), decode, a data word
// read for loads and indirect jumps, execute and a word store for stores, over
// the memory's one byte port; the next item is accepted the cycle after transfer.
// One item is in flight at a time; tready falls from acceptance until the
// result transfer completes, so a stalled receiver holds the block.
// Reset clears registers, pc, halt flag and control, then a clearing pass
// zeroes all 65536 memory bytes with tready low. i_cfg_we loads the program
// counter from i_cfg_wdata, only while clearing or idle without a byte load.
module sm213_instruction_step_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // load_address[15:0], load_byte[23:16]
    input  logic         s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pc_after[31:0], reg_index[34:32], reg_value[66:35], store_address[82:67],
    // store_value[114:83], zero fill above
    output logic [119:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser   // halted, illegal, reg_written, mem_written
);
    sm213_pkg::t_ctl w_ctl;
    sm213_pkg::t_sts w_sts;
    logic [31:0] w_pc, w_rv, w_sv;
    logic [15:0] w_sa;
    logic [2:0]  w_ri;
    logic        w_ill, w_rw, w_mw, w_start;

    assign w_start = s_axis_tvalid && s_axis_tready;

    sm213_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_start(w_start), .i_kind(s_axis_tuser), .i_sts(w_sts),
        .i_out_ready(m_axis_tready), .o_ctl(w_ctl),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    sm213_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_cfg_pc(i_cfg_wdata),
        .i_load_address(s_axis_tdata[15:0]), .i_load_byte(s_axis_tdata[23:16]),
        .o_sts(w_sts), .o_pc(w_pc), .o_illegal(w_ill), .o_reg_written(w_rw),
        .o_reg_index(w_ri), .o_reg_value(w_rv), .o_mem_written(w_mw),
        .o_store_address(w_sa), .o_store_value(w_sv)
    );

    assign m_axis_tdata = {5'd0, w_sv, w_sa, w_rv, w_ri, w_pc};
    assign m_axis_tuser = {w_mw, w_rw, w_ill, w_sts.halted};
endmodule

// ===== src/sm213_ram.sv =====
`timescale 1ns / 1ps
module sm213_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/sm213_datapath.sv =====
`timescale 1ns / 1ps
module sm213_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sm213_pkg::t_ctl        i_ctl,
    input  logic [15:0]            i_cfg_pc,
    input  logic [15:0]            i_load_address,
    input  logic [7:0]             i_load_byte,
    output sm213_pkg::t_sts        o_sts,
    output logic [31:0]            o_pc,
    output logic                   o_illegal,
    output logic                   o_reg_written,
    output logic [2:0]             o_reg_index,
    output logic [31:0]            o_reg_value,
    output logic                   o_mem_written,
    output logic [15:0]            o_store_address,
    output logic [31:0]            o_store_value
);
    localparam int AW = sm213_pkg::AddrW;

    logic [31:0] r_regs [sm213_pkg::NumRegs];
    logic [31:0] r_pc, r_ext, r_daddr, r_word;
    logic [7:0]  r_b0, r_b1;
    logic        r_halt;
    logic [31:0] r_rv, r_sv, r_sa;
    logic        r_ill, r_rw, r_mw;
    logic [2:0]  r_ri;
    logic [AW-1:0] r_clr;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata, w_rdata;

    logic [3:0] w_op, w_o0, w_o1, w_o2;
    logic [31:0] w_r0, w_r1, w_r2, w_imm, w_pc2;
    logic [5:0]  w_shn;

    assign w_op = r_b0[7:4];
    assign w_o0 = r_b0[3:0];
    assign w_o1 = r_b1[7:4];
    assign w_o2 = r_b1[3:0];
    assign w_r0 = r_regs[w_o0[2:0]];
    assign w_r1 = r_regs[w_o1[2:0]];
    assign w_r2 = r_regs[w_o2[2:0]];
    assign w_imm = {{24{r_b1[7]}}, r_b1};
    assign w_pc2 = r_pc + 32'd2;

    sm213_ram #(.Width(8), .Depth(sm213_pkg::MemBytes)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    always_comb begin
        w_we = 1'b0;
        w_wdata = i_load_byte;
        w_addr = i_load_address[AW-1:0];
        case (i_ctl.cmd)
            sm213_pkg::CMD_LOAD: w_we = 1'b1;
            sm213_pkg::CMD_FETCH: w_addr = r_pc[AW-1:0] + AW'(i_ctl.idx);
            sm213_pkg::CMD_DREAD: w_addr = r_daddr[AW-1:0] + AW'(i_ctl.idx);
            sm213_pkg::CMD_STORE: begin
                w_we = 1'b1;
                w_addr = r_sa[AW-1:0] + AW'(i_ctl.idx);
                w_wdata = r_sv[8*(3-i_ctl.idx[1:0]) +: 8];
            end
            sm213_pkg::CMD_CLEAR: begin
                w_we = 1'b1;
                w_addr = r_clr;
                w_wdata = 8'd0;
            end
            default: ;
        endcase
    end

    assign o_sts.op = w_op;
    assign o_sts.halted = r_halt;
    assign o_sts.needs_ext = (w_op == sm213_pkg::OP_LDI) || (w_op == sm213_pkg::OP_JMP);
    assign o_sts.needs_data = (w_op == sm213_pkg::OP_LDO) || (w_op == sm213_pkg::OP_LDX) ||
                              (w_op == sm213_pkg::OP_JIO) || (w_op == sm213_pkg::OP_JIX);
    assign o_sts.stores = (w_op == sm213_pkg::OP_STO) || (w_op == sm213_pkg::OP_STX);
    assign o_sts.clear_done = (r_clr == '1);

    // shift result, computed from registers only
    logic [31:0] w_shr;
    logic        w_left;
    assign w_left = !r_b1[7] && (r_b1 != 8'd0);
    assign w_shn = w_left ? ((r_b1 >= 8'd32) ? 6'd32 : r_b1[5:0])
                          : (((-r_b1) >= 8'd32 || r_b1 == 8'h80) ? 6'd32 : 6'((-r_b1)));
    always_comb begin
        if (w_left) begin
            w_shr = (w_shn[5]) ? 32'd0 : (w_r0 << w_shn[4:0]);
        end else begin
            w_shr = (w_shn[5]) ? {32{w_r0[31]}} : 32'($signed(w_r0) >>> w_shn[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 32'd0;
            r_halt <= 1'b0;
            r_clr <= '0;
            for (int i = 0; i < sm213_pkg::NumRegs; i++) r_regs[i] <= 32'd0;
        end else begin
            if (i_ctl.lat) begin
                r_word <= {r_word[23:0], w_rdata};
                // instruction bytes come back only during fetch
                if (i_ctl.cmd == sm213_pkg::CMD_FETCH && i_ctl.idx == 3'd1) r_b0 <= w_rdata;
                if (i_ctl.cmd == sm213_pkg::CMD_FETCH && i_ctl.idx == 3'd2) r_b1 <= w_rdata;
            end
            unique case (i_ctl.cmd)
                sm213_pkg::CMD_NONE: if (i_ctl.pcload) r_pc <= {16'd0, i_cfg_pc};
                sm213_pkg::CMD_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (i_ctl.pcload) r_pc <= {16'd0, i_cfg_pc};
                end
                sm213_pkg::CMD_LOAD: begin
                    r_ill <= 1'b0; r_rw <= 1'b0; r_mw <= 1'b0;
                    r_ri <= 3'd0; r_rv <= 32'd0; r_sa <= 32'd0; r_sv <= 32'd0;
                end
                sm213_pkg::CMD_DECODE: begin
                    r_ext <= r_word;
                    r_ill <= 1'b0; r_rw <= 1'b0; r_mw <= 1'b0;
                    r_ri <= 3'd0; r_rv <= 32'd0; r_sa <= 32'd0; r_sv <= 32'd0;
                    case (w_op)
                        sm213_pkg::OP_LDO: r_daddr <= {26'd0, w_o0, 2'b00} + w_r1;
                        sm213_pkg::OP_LDX, sm213_pkg::OP_JIX:
                            r_daddr <= w_r0 + {w_r1[29:0], 2'b00};
                        sm213_pkg::OP_JIO: r_daddr <= w_r0 + {22'd0, r_b1, 2'b00};
                        default: r_daddr <= 32'd0;
                    endcase
                end
                sm213_pkg::CMD_EXEC: begin
                    r_pc <= w_pc2;
                    case (w_op)
                        sm213_pkg::OP_LDI: begin
                            r_rw <= 1'b1; r_ri <= w_o0[2:0]; r_rv <= r_ext;
                            r_regs[w_o0[2:0]] <= r_ext; r_pc <= r_pc + 32'd6;
                        end
                        sm213_pkg::OP_LDO, sm213_pkg::OP_LDX: begin
                            r_rw <= 1'b1; r_ri <= w_o2[2:0]; r_rv <= r_word;
                            r_regs[w_o2[2:0]] <= r_word;
                        end
                        sm213_pkg::OP_STO: begin
                            r_mw <= 1'b1; r_sv <= w_r0;
                            r_sa <= {16'd0, 16'({26'd0, w_o1, 2'b00} + w_r2)};
                        end
                        sm213_pkg::OP_STX: begin
                            r_mw <= 1'b1; r_sv <= w_r0;
                            r_sa <= {16'd0, 16'(w_r1 + {w_r2[29:0], 2'b00})};
                        end
                        sm213_pkg::OP_ALU: begin
                            r_rw <= 1'b1; r_ri <= w_o2[2:0];
                            case (w_o0)
                                4'h0: begin r_rv <= w_r1; r_regs[w_o2[2:0]] <= w_r1; end
                                4'h1: begin r_rv <= w_r1 + w_r2;
                                      r_regs[w_o2[2:0]] <= w_r1 + w_r2; end
                                4'h2: begin r_rv <= w_r1 & w_r2;
                                      r_regs[w_o2[2:0]] <= w_r1 & w_r2; end
                                4'h3: begin r_rv <= w_r2 + 32'd1;
                                      r_regs[w_o2[2:0]] <= w_r2 + 32'd1; end
                                4'h4: begin r_rv <= w_r2 + 32'd4;
                                      r_regs[w_o2[2:0]] <= w_r2 + 32'd4; end
                                4'h5: begin r_rv <= w_r2 - 32'd1;
                                      r_regs[w_o2[2:0]] <= w_r2 - 32'd1; end
                                4'h6: begin r_rv <= w_r2 - 32'd4;
                                      r_regs[w_o2[2:0]] <= w_r2 - 32'd4; end
                                4'h7: begin r_rv <= ~w_r2; r_regs[w_o2[2:0]] <= ~w_r2; end
                                4'hf: begin r_rv <= w_pc2 + {27'd0, w_o1, 1'b0};
                                      r_regs[w_o2[2:0]] <= w_pc2 + {27'd0, w_o1, 1'b0}; end
                                default: begin r_rw <= 1'b0; r_ri <= 3'd0; r_ill <= 1'b1; end
                            endcase
                        end
                        sm213_pkg::OP_SHF: begin
                            r_rw <= 1'b1; r_ri <= w_o0[2:0]; r_rv <= w_shr;
                            r_regs[w_o0[2:0]] <= w_shr;
                        end
                        sm213_pkg::OP_BR: r_pc <= w_pc2 + {w_imm[30:0], 1'b0};
                        sm213_pkg::OP_BEQ:
                            if (w_r0 == 32'd0) r_pc <= w_pc2 + {w_imm[30:0], 1'b0};
                        sm213_pkg::OP_BGT:
                            if (w_r0 != 32'd0 && !w_r0[31])
                                r_pc <= w_pc2 + {w_imm[30:0], 1'b0};
                        sm213_pkg::OP_JMP: r_pc <= r_ext;
                        sm213_pkg::OP_JR: r_pc <= {23'd0, r_b1, 1'b0} + w_r0;
                        sm213_pkg::OP_JIO, sm213_pkg::OP_JIX: r_pc <= r_word;
                        sm213_pkg::OP_HLT: if (w_o0 == 4'd0) r_halt <= 1'b1;
                        default: r_ill <= 1'b1;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_pc = r_pc;
    assign o_illegal = r_ill;
    assign o_reg_written = r_rw;
    assign o_reg_index = r_ri;
    assign o_reg_value = r_rv;
    assign o_mem_written = r_mw;
    assign o_store_address = r_sa[15:0];
    assign o_store_value = r_sv;
endmodule

// ===== src/sm213_ctrl.sv =====
`timescale 1ns / 1ps
module sm213_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_start,
    input  logic            i_kind,
    input  sm213_pkg::t_sts i_sts,
    input  logic            i_out_ready,
    output sm213_pkg::t_ctl o_ctl,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DEC, S_DATA, S_EXEC, S_STORE
    } t_state;

    t_state     r_state;
    logic [2:0] r_idx;
    logic       r_lat;
    logic       r_out;

    always_comb begin
        o_ctl.cmd = sm213_pkg::CMD_NONE;
        o_ctl.idx = r_idx;
        o_ctl.lat = r_lat;
        o_ctl.pcload = i_cfg_we;
        unique case (r_state)
            S_CLEAR: o_ctl.cmd = sm213_pkg::CMD_CLEAR;
            S_IDLE: if (i_start) o_ctl.cmd = i_kind ? sm213_pkg::CMD_NONE
                                                    : sm213_pkg::CMD_LOAD;
            S_FETCH: o_ctl.cmd = sm213_pkg::CMD_FETCH;
            S_DEC: o_ctl.cmd = sm213_pkg::CMD_DECODE;
            S_DATA: o_ctl.cmd = sm213_pkg::CMD_DREAD;
            S_EXEC: o_ctl.cmd = sm213_pkg::CMD_EXEC;
            S_STORE: o_ctl.cmd = sm213_pkg::CMD_STORE;
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_out;
    assign o_out_valid = r_out;

    // fetch reads bytes 0..n-1 through the registered memory read; lat captures the
    // byte issued the cycle before, idx then names the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= 3'd0;
            r_lat <= 1'b0;
            r_out <= 1'b0;
        end else begin
            if (r_out && i_out_ready) r_out <= 1'b0;
            r_lat <= 1'b0;
            unique case (r_state)
                S_CLEAR: if (i_sts.clear_done) r_state <= S_IDLE;
                S_IDLE: if (i_start) begin
                    if (!i_kind || i_sts.halted) begin
                        r_out <= 1'b1;
                    end else begin
                        r_state <= S_FETCH;
                        r_idx <= 3'd0;
                    end
                end
                S_FETCH: begin
                    r_lat <= 1'b1;
                    r_idx <= r_idx + 3'd1;
                    // byte at idx returns next cycle; b0/b1 captured at idx 1/2
                    if (r_idx == 3'd2 && !i_sts.needs_ext) begin
                        r_lat <= 1'b0;
                        r_state <= S_DEC;
                    end else if (r_idx == 3'd6) begin
                        r_lat <= 1'b0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_idx <= 3'd0;
                    r_state <= i_sts.needs_data ? S_DATA : S_EXEC;
                end
                S_DATA: begin
                    r_lat <= (r_idx != 3'd4);
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd4) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_idx <= 3'd0;
                    if (i_sts.stores) begin
                        r_state <= S_STORE;
                    end else begin
                        r_state <= S_IDLE;
                        r_out <= 1'b1;
                    end
                end
                S_STORE: begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd3) begin
                        r_state <= S_IDLE;
                        r_out <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
